>>> rtl/core/hcjs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash-chained journal store package
// Shared types, command and outcome codes, slot word layout and the FNV-1a
// byte step used by the journal store.
// ----------------------------------------------------------------------------
package hcjs_pkg;

    localparam int SLOT_COUNT_DEFAULT = 1024;
    localparam int SEQ_W              = 11;
    localparam int SEQ_MAX            = 2047;
    localparam int WORDS_PER_SLOT     = 6;

    localparam logic [63:0] FNV_OFFSET = 64'hCBF2_9CE4_8422_2325;

    localparam logic [1:0] CMD_RESERVE = 2'd0;
    localparam logic [1:0] CMD_COMMIT  = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    localparam logic [1:0] OUT_OK       = 2'd0;
    localparam logic [1:0] OUT_REJECT   = 2'd1;
    localparam logic [1:0] OUT_MISMATCH = 2'd2;

    // Word positions inside one slot of the word memory.
    localparam logic [2:0] W_EVT   = 3'd0;
    localparam logic [2:0] W_JSEQ  = 3'd1;
    localparam logic [2:0] W_SSEQ  = 3'd2;
    localparam logic [2:0] W_SHASH = 3'd3;
    localparam logic [2:0] W_PREV  = 3'd4;
    localparam logic [2:0] W_REC   = 3'd5;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_HASH,
        S_FINAL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [3:0]       pad;
        logic [63:0]      snapshot_digest;
        logic [63:0]      snapshot_seq;
        logic [63:0]      result_journal_seq;
        logic [7:0]       invariant_code;
        logic [7:0]       apply_status;
        logic [63:0]      event_hash;
        logic             reservation_valid;
        logic [SEQ_W-1:0] sequence_req;
    } in_item_t;

    typedef struct packed {
        logic [63:0]      chain_head_hash;
        logic [SEQ_W-1:0] published_count;
        logic [63:0]      out_record_hash;
        logic [63:0]      out_previous_hash;
        logic [63:0]      out_snapshot_hash;
        logic [63:0]      out_snapshot_seq;
        logic [63:0]      out_journal_seq;
        logic [7:0]       out_invariant;
        logic [7:0]       out_status;
        logic [63:0]      out_event_hash;
        logic [SEQ_W-1:0] out_sequence;
        logic [1:0]       outcome;
    } result_t;

    // One FNV-1a step: xor in a byte, then multiply by the prime 2^40 + 0x1b3.
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

endpackage

>>> rtl/core/hcjs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hcjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/hash_chained_journal_store_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash-chained journal store
// Append-only journal of record slots linked by a 64-bit FNV-1a hash chain,
// with reserve, commit and read commands and one shared byte-step hash unit.
// ----------------------------------------------------------------------------
//  Channel   Direction  Bits  Contents
//  s_axis    in         288   tdata: record fields, tuser: command
//  m_axis    out        488   tdata: outcome, record fields, count, head hash
//
//  Reserve and requests rejected by the range checks go straight to the result;
//  a read of an unpublished slot ends after the word and code memory fetch.
//  Commit and read run the 64 serial FNV byte steps on the shared multiply-by-prime
//  unit, besides their word memory access.
//  After reset a clearing pass writes all min(SLOT_COUNT, 2047) slot code memory
//  entries, one entry per cycle, before s_tready rises.
//  A finished result waits in the output register; new input is taken meanwhile.
module hash_chained_journal_store_unit #(
    parameter int SLOT_COUNT = hcjs_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // sequence_req, reservation_valid, event_hash, apply_status, invariant_code,
    // result_journal_seq, snapshot_seq, snapshot_digest, 4 zero bits
    input  logic [287:0]           s_tdata,
    // command
    input  logic [1:0]             s_tuser,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // outcome, out_sequence, out_event_hash, out_status, out_invariant,
    // out_journal_seq, out_snapshot_seq, out_snapshot_hash, out_previous_hash,
    // out_record_hash, published_count, chain_head_hash
    output logic [487:0]           m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready
);

    import hcjs_pkg::*;

    localparam int DEPTH  = (SLOT_COUNT < SEQ_MAX) ? SLOT_COUNT : SEQ_MAX;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WDEPTH = DEPTH * WORDS_PER_SLOT;
    localparam int WA_W   = $clog2(WDEPTH);
    localparam int RC_W   = $clog2(SLOT_COUNT + 1);

    state_t           state_reg, state_next;
    logic [RC_W-1:0]  rsv_cnt_reg, rsv_cnt_next;
    logic [SEQ_W-1:0] pub_reg, pub_next;
    logic [63:0]      head_reg, head_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic             m_tvalid_reg, m_tvalid_next;
    result_t          m_tdata_reg, m_tdata_next;

    logic [1:0]       cmd_reg, cmd_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [WA_W-1:0]  base_reg, base_next;
    logic [63:0]      evt_reg, evt_next;
    logic [7:0]       st_reg, st_next;
    logic [7:0]       inv_reg, inv_next;
    logic [63:0]      jseq_reg, jseq_next;
    logic [63:0]      sseq_reg, sseq_next;
    logic [63:0]      shash_reg, shash_next;
    logic [63:0]      prev_reg, prev_next;
    logic [63:0]      rec_reg, rec_next;
    logic [63:0]      hash_reg, hash_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [1:0]       outcome_reg, outcome_next;

    in_item_t         s_item;
    logic             in_range;
    logic [63:0]      hash_word;
    logic [7:0]       hash_byte;
    logic [63:0]      hash_fixed;
    logic             ok;
    logic             cmd_rec;

    logic             word_we;
    logic [WA_W-1:0]  word_waddr;
    logic [63:0]      word_wdata;
    logic [WA_W-1:0]  word_raddr;
    logic [63:0]      word_rdata;
    logic             code_we;
    logic [IDX_W-1:0] code_waddr;
    logic [16:0]      code_wdata;
    logic [16:0]      code_rdata;

    hcjs_ram #(
        .WIDTH(64),
        .DEPTH(WDEPTH)
    ) u_word_ram (
        .aclk  (aclk),
        .we    (word_we),
        .waddr (word_waddr),
        .wdata (word_wdata),
        .raddr (word_raddr),
        .rdata (word_rdata)
    );

    // Each code entry holds a published flag, the status byte and the invariant byte.
    hcjs_ram #(
        .WIDTH(17),
        .DEPTH(DEPTH)
    ) u_code_ram (
        .aclk  (aclk),
        .we    (code_we),
        .waddr (code_waddr),
        .wdata (code_wdata),
        .raddr (idx_reg),
        .rdata (code_rdata)
    );

    assign s_item   = in_item_t'(s_tdata);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_range = (s_item.sequence_req != '0) &&
                      (32'(s_item.sequence_req) <= 32'(SLOT_COUNT));

    always_comb begin
        unique case (cnt_reg[5:3])
            3'd0:    hash_word = 64'(seq_reg);
            3'd1:    hash_word = evt_reg;
            3'd2:    hash_word = 64'(st_reg);
            3'd3:    hash_word = 64'(inv_reg);
            3'd4:    hash_word = jseq_reg;
            3'd5:    hash_word = sseq_reg;
            3'd6:    hash_word = shash_reg;
            default: hash_word = prev_reg;
        endcase
    end

    assign hash_byte  = 8'(hash_word >> {cnt_reg[2:0], 3'b000});
    assign hash_fixed = (hash_reg == '0) ? 64'd1 : hash_reg;
    assign ok         = (outcome_reg != OUT_REJECT);
    assign cmd_rec    = (cmd_reg == CMD_COMMIT) || (cmd_reg == CMD_READ);
    assign word_raddr = base_reg + WA_W'(cnt_reg[2:0]);

    always_comb begin
        state_next    = state_reg;
        rsv_cnt_next  = rsv_cnt_reg;
        pub_next      = pub_reg;
        head_next     = head_reg;
        clr_next      = clr_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        cmd_next      = cmd_reg;
        seq_next      = seq_reg;
        idx_next      = idx_reg;
        base_next     = base_reg;
        evt_next      = evt_reg;
        st_next       = st_reg;
        inv_next      = inv_reg;
        jseq_next     = jseq_reg;
        sseq_next     = sseq_reg;
        shash_next    = shash_reg;
        prev_next     = prev_reg;
        rec_next      = rec_reg;
        hash_next     = hash_reg;
        cnt_next      = cnt_reg;
        outcome_next  = outcome_reg;
        word_we       = 1'b0;
        word_waddr    = base_reg + WA_W'(cnt_reg[2:0]);
        word_wdata    = '0;
        code_we       = 1'b0;
        code_waddr    = idx_reg;
        code_wdata    = {1'b1, st_reg, inv_reg};

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                code_we    = 1'b1;
                code_waddr = clr_reg;
                code_wdata = '0;
                clr_next   = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next     = s_tuser;
                    seq_next     = s_item.sequence_req;
                    idx_next     = IDX_W'(s_item.sequence_req - SEQ_W'(1));
                    base_next    = (WA_W'(idx_next) << 2) + (WA_W'(idx_next) << 1);
                    evt_next     = s_item.event_hash;
                    st_next      = s_item.apply_status;
                    inv_next     = s_item.invariant_code;
                    jseq_next    = s_item.result_journal_seq;
                    sseq_next    = s_item.snapshot_seq;
                    shash_next   = s_item.snapshot_digest;
                    prev_next    = head_reg;
                    hash_next    = FNV_OFFSET;
                    cnt_next     = '0;
                    outcome_next = OUT_REJECT;
                    state_next   = S_DONE;
                    unique case (s_tuser)
                        CMD_RESERVE: begin
                            if (32'(rsv_cnt_reg) < 32'(SLOT_COUNT)) begin
                                rsv_cnt_next = rsv_cnt_reg + RC_W'(1);
                                seq_next     = SEQ_W'(rsv_cnt_next);
                                outcome_next = OUT_OK;
                            end
                        end
                        CMD_COMMIT: begin
                            if (s_item.reservation_valid && in_range) begin
                                state_next = S_HASH;
                            end
                        end
                        CMD_READ: begin
                            if (in_range && (s_item.sequence_req <= pub_reg)) begin
                                state_next = S_FETCH;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                cnt_next = cnt_reg + 6'd1;
                unique case (cnt_reg[2:0])
                    3'd1:    evt_next   = word_rdata;
                    3'd2:    jseq_next  = word_rdata;
                    3'd3:    sseq_next  = word_rdata;
                    3'd4:    shash_next = word_rdata;
                    3'd5:    prev_next  = word_rdata;
                    3'd6:    rec_next   = word_rdata;
                    default: begin
                    end
                endcase
                if (cnt_reg[2:0] == 3'd6) begin
                    st_next  = code_rdata[15:8];
                    inv_next = code_rdata[7:0];
                    cnt_next = '0;
                    if (code_rdata[16]) begin
                        state_next = S_HASH;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_HASH: begin
                hash_next = fnv_step(hash_reg, hash_byte);
                cnt_next  = cnt_reg + 6'd1;
                if ((cmd_reg == CMD_COMMIT) && (cnt_reg[5:3] == 3'd0) &&
                    (cnt_reg[2:0] <= W_PREV)) begin
                    word_we = 1'b1;
                end
                unique case (cnt_reg[2:0])
                    W_EVT:   word_wdata = evt_reg;
                    W_JSEQ:  word_wdata = jseq_reg;
                    W_SSEQ:  word_wdata = sseq_reg;
                    W_SHASH: word_wdata = shash_reg;
                    W_PREV:  word_wdata = prev_reg;
                    default: word_wdata = '0;
                endcase
                if (cnt_reg == 6'd63) begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL: begin
                state_next = S_DONE;
                if (cmd_reg == CMD_COMMIT) begin
                    word_we      = 1'b1;
                    word_waddr   = base_reg + WA_W'(W_REC);
                    word_wdata   = hash_fixed;
                    code_we      = 1'b1;
                    head_next    = hash_fixed;
                    pub_next     = seq_reg;
                    rec_next     = hash_fixed;
                    outcome_next = OUT_OK;
                end else begin
                    outcome_next = (hash_fixed == rec_reg) ? OUT_OK : OUT_MISMATCH;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next                  = 1'b1;
                    m_tdata_next                   = '0;
                    m_tdata_next.outcome           = outcome_reg;
                    m_tdata_next.published_count   = pub_reg;
                    m_tdata_next.chain_head_hash   = head_reg;
                    if (ok) begin
                        m_tdata_next.out_sequence = seq_reg;
                    end
                    if (ok && cmd_rec) begin
                        m_tdata_next.out_record_hash = rec_reg;
                    end
                    if (ok && (cmd_reg == CMD_READ)) begin
                        m_tdata_next.out_event_hash    = evt_reg;
                        m_tdata_next.out_status        = st_reg;
                        m_tdata_next.out_invariant     = inv_reg;
                        m_tdata_next.out_journal_seq   = jseq_reg;
                        m_tdata_next.out_snapshot_seq  = sseq_reg;
                        m_tdata_next.out_snapshot_hash = shash_reg;
                        m_tdata_next.out_previous_hash = prev_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            rsv_cnt_reg  <= '0;
            pub_reg      <= '0;
            head_reg     <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rsv_cnt_reg  <= rsv_cnt_next;
            pub_reg      <= pub_next;
            head_reg     <= head_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        cmd_reg     <= cmd_next;
        seq_reg     <= seq_next;
        idx_reg     <= idx_next;
        base_reg    <= base_next;
        evt_reg     <= evt_next;
        st_reg      <= st_next;
        inv_reg     <= inv_next;
        jseq_reg    <= jseq_next;
        sseq_reg    <= sseq_next;
        shash_reg   <= shash_next;
        prev_reg    <= prev_next;
        rec_reg     <= rec_next;
        hash_reg    <= hash_next;
        cnt_reg     <= cnt_next;
        outcome_reg <= outcome_next;
    end

    a_head_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (pub_reg != '0) |-> (head_reg != '0))
        else $error("Chain head hash is zero while a record is published.");

    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_tdata_reg.outcome == OUT_REJECT)) |->
        ((m_tdata_reg.out_sequence == '0) && (m_tdata_reg.out_record_hash == '0)))
        else $error("Rejected result carries record fields.");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("Result presented without a finished item.");

    a_commit_links_head: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(state_reg == S_FINAL) && (cmd_reg == CMD_COMMIT)) |->
        (head_reg == rec_reg))
        else $error("Commit did not move the chain head to the new record hash.");

endmodule
